// ----- sv/pcle_pkg.sv -----
// shared types and constants for the positional character list engine
package pcle_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int MAX_RESULTS = 32;
	localparam int IDX_W = 8;

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_DEL,
		CMD_GET,
		CMD_PRINT
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_INVALID,
		ST_FULL
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_PRINT
	} state_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INS,
		OP_DEL
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

// ----- sv/pcle_cell.sv -----
// one list cell: holds a character, shifts toward either neighbor, answers a read
module pcle_cell import pcle_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  logic [7:0]      item,
	input  logic [7:0]      left,
	input  logic [7:0]      right,
	output logic [7:0]      char_out,
	output logic [7:0]      rd
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [7:0] char_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (MY_IDX > ctl.idx) begin
					char_q <= left;
				end else if (MY_IDX == ctl.idx) begin
					char_q <= item;
				end
			end
			OP_DEL: begin
				if (MY_IDX >= ctl.idx) begin
					char_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign char_out = char_q;
	assign rd = (MY_IDX == ctl.idx) ? char_q : 8'd0;

endmodule

// ----- sv/positional_char_list_engine_core.sv -----
// top level of the positional character list engine
//
//  channel   signals                          handshake
//  command   cmd, position, item              start && !busy
//  result    status, data, data_valid, last   strobe, one cycle, no back-pressure
//
// add, delete and get: one result beat in the cycle after the command, busy stays low
// print: busy for min(count, 32) cycles, one beat per cycle through the shared read select
// a new command may be taken in the cycle the last print beat is shown
// reset clears the fill count and the control state; cell contents stay undefined
// the receiver cannot stall, so there is no output holding
module positional_char_list_engine_core import pcle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] position,
	input  logic [7:0] item,
	output logic       strobe,
	output logic [1:0] status,
	output logic [7:0] data,
	output logic       data_valid,
	output logic       last
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(MAX_RESULTS);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [PW-1:0]   ptr_q, ptr_d;
	logic [PW-1:0]   plim_q, plim_d;
	logic            strobe_q, strobe_d;
	status_t         status_q, status_d;
	logic [7:0]      data_q, data_d;
	logic            dv_q, dv_d;
	logic            last_q, last_d;

	cell_ctl_t       ctl;
	logic [7:0]      cell_q [CAPACITY];
	logic [7:0]      cell_rd [CAPACITY];
	logic [7:0]      rd_data;
	logic            accept;
	logic            add_ok;
	logic            rd_ok;
	logic            full;
	logic [7:0]      pos_m1;
	logic [PW-1:0]   plim_new;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [7:0] left;
		logic [7:0] right;
		if (g == 0) begin : g_first
			assign left = item;
		end else begin : g_mid
			assign left = cell_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_end
			assign right = 8'd0;
		end else begin : g_next
			assign right = cell_q[g+1];
		end
		pcle_cell #(
			.IDX(g)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.item(item),
			.left(left),
			.right(right),
			.char_out(cell_q[g]),
			.rd(cell_rd[g])
		);
	end

	always_comb begin
		rd_data = 8'd0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | cell_rd[i];
		end
	end

	assign busy = (state_q == S_PRINT);
	assign accept = start && !busy;
	assign pos_m1 = position - 8'd1;
	assign add_ok = (position != 8'd0) && (9'(position) <= 9'(count_q) + 9'd1);
	assign rd_ok = (position != 8'd0) && (9'(position) <= 9'(count_q));
	assign full = (9'(count_q) == 9'(CAPACITY));
	assign plim_new = (9'(count_q) >= 9'(MAX_RESULTS)) ? PW'(MAX_RESULTS - 1)
		: PW'(count_q - CW'(1));

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d = ptr_q;
		plim_d = plim_q;
		strobe_d = 1'b0;
		status_d = ST_OK;
		data_d = 8'd0;
		dv_d = 1'b0;
		last_d = 1'b0;
		ctl.op = OP_HOLD;
		ctl.idx = pos_m1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(cmd))
						CMD_ADD: begin
							strobe_d = 1'b1;
							last_d = 1'b1;
							if (!add_ok) begin
								status_d = ST_INVALID;
							end else if (full) begin
								status_d = ST_FULL;
							end else begin
								ctl.op = OP_INS;
								count_d = count_q + CW'(1);
							end
						end
						CMD_DEL, CMD_GET: begin
							strobe_d = 1'b1;
							last_d = 1'b1;
							if (!rd_ok) begin
								status_d = ST_INVALID;
							end else begin
								data_d = rd_data;
								dv_d = 1'b1;
								if (cmd_t'(cmd) == CMD_DEL) begin
									ctl.op = OP_DEL;
									count_d = count_q - CW'(1);
								end
							end
						end
						CMD_PRINT: begin
							if (count_q == '0) begin
								strobe_d = 1'b1;
								last_d = 1'b1;
							end else begin
								state_d = S_PRINT;
								ptr_d = '0;
								plim_d = plim_new;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PRINT: begin
				ctl.idx = IDX_W'(ptr_q);
				strobe_d = 1'b1;
				data_d = rd_data;
				dv_d = 1'b1;
				last_d = (ptr_q == plim_q);
				if (ptr_q == plim_q) begin
					state_d = S_IDLE;
				end else begin
					ptr_d = ptr_q + PW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		plim_q <= plim_d;
		status_q <= status_d;
		data_q <= data_d;
		dv_q <= dv_d;
		last_q <= last_d;
	end

	assign strobe = strobe_q;
	assign status = status_q;
	assign data = data_q;
	assign data_valid = dv_q;
	assign last = last_q;

endmodule

// ----- sv/pcle_checker.sv -----
// port-level checks for the engine core and their binding
module pcle_checker import pcle_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] cmd,
	input logic       strobe,
	input logic [1:0] status,
	input logic       data_valid,
	input logic       last
);

	// a print stream has no gaps
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("print stream broke before its last beat");

	// single-beat commands answer in the next cycle
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd != CMD_PRINT) |=> strobe && last)
		else $error("command did not answer with one last beat");

	// an error beat carries no character and ends the command
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status != ST_OK) |-> !data_valid && last)
		else $error("error beat with data or without last");

	// only add reports full
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (status == ST_FULL) |-> $past(start) && ($past(cmd) == CMD_ADD))
		else $error("full status without an add");

endmodule

bind positional_char_list_engine_core pcle_checker u_pcle_checker (.*);

// ----- tb/sv/pcle_list_checker.sv -----
// checker for the positional character list engine: predicts result beats and compares them
module pcle_list_checker import pcle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] position,
	input  logic [7:0] item,
	input  logic       strobe,
	input  logic [1:0] status,
	input  logic [7:0] data,
	input  logic       data_valid,
	input  logic       last,
	output int         errors,
	output int         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0] st;
		logic [7:0] ch;
		logic       ch_valid;
		logic       is_last;
	} beat_t;

	beat_t      expected_beats[$];
	logic [7:0] chars [CAPACITY];
	int         fill = 0;
	int         fail_count = 0;

	function automatic void push_beat(logic [1:0] st, logic [7:0] ch, logic v, logic l);
		beat_t b;
		b = {st, ch, v, l};
		expected_beats.push_back(b);
	endfunction

	function automatic void predict_list_cmd(logic [1:0] c, logic [7:0] p, logic [7:0] it);
		int         pos;
		int         n_out;
		logic [7:0] ch;
		pos = p;
		case (c)
			CMD_ADD: begin
				if (pos == 0 || pos > fill + 1) begin
					push_beat(ST_INVALID, 8'h00, 1'b0, 1'b1);
				end else if (fill >= CAPACITY) begin
					push_beat(ST_FULL, 8'h00, 1'b0, 1'b1);
				end else begin
					for (int i = fill; i >= pos; i--)
						chars[i] = chars[i-1];
					chars[pos-1] = it;
					fill++;
					push_beat(ST_OK, 8'h00, 1'b0, 1'b1);
				end
			end
			CMD_DEL, CMD_GET: begin
				if (pos == 0 || pos > fill) begin
					push_beat(ST_INVALID, 8'h00, 1'b0, 1'b1);
				end else begin
					ch = chars[pos-1];
					if (c == CMD_DEL) begin
						for (int i = pos; i < fill; i++)
							chars[i-1] = chars[i];
						fill--;
					end
					push_beat(ST_OK, ch, 1'b1, 1'b1);
				end
			end
			default: begin
				n_out = (fill > MAX_RESULTS) ? MAX_RESULTS : fill;
				if (n_out == 0) begin
					push_beat(ST_OK, 8'h00, 1'b0, 1'b1);
				end else begin
					for (int i = 0; i < n_out; i++)
						push_beat(ST_OK, chars[i], 1'b1, i == n_out - 1);
				end
			end
		endcase
	endfunction

	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n) begin
			if (strobe) begin
				got = {status, data, data_valid, last};
				if (expected_beats.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected beat, expected none, ", $time,
						"got status %0d data %h valid %b last %b",
						status, data, data_valid, last);
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						fail_count++;
						$display("%0t: beat mismatch, ", $time,
							"expected status %0d data %h valid %b last %b, ",
							want.st, want.ch, want.ch_valid, want.is_last,
							"got status %0d data %h valid %b last %b",
							status, data, data_valid, last);
					end
				end
			end
			if (start && !busy)
				predict_list_cmd(cmd, position, item);
		end
		errors <= fail_count;
		outstanding <= expected_beats.size();
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for the positional character list engine: stimulus, watchdog and verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pcle_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int N_RANDOM = 101;
	localparam int DRAIN_CYCLES = 40;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [1:0] cmd;
	logic [7:0] position;
	logic [7:0] item;
	logic       strobe;
	logic [1:0] status;
	logic [7:0] data;
	logic       data_valid;
	logic       last;
	int         errors;
	int         outstanding;
	int         fill;
	int         burst_left;
	int         stall_cycles = 0;

	positional_char_list_engine_core #(.CAPACITY(CAPACITY_DEF)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.position   (position),
		.item       (item),
		.strobe     (strobe),
		.status     (status),
		.data       (data),
		.data_valid (data_valid),
		.last       (last)
	);

	pcle_list_checker #(.CAPACITY(CAPACITY_DEF)) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.position    (position),
		.item        (item),
		.strobe      (strobe),
		.status      (status),
		.data        (data),
		.data_valid  (data_valid),
		.last        (last),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_cmd(cmd_t c, logic [7:0] p, logic [7:0] it);
		start <= 1'b1;
		cmd <= c;
		position <= p;
		item <= it;
		do @(posedge clk); while (busy);
		// track fill level to steer positions
		if (c == CMD_ADD && p >= 1 && p <= fill + 1 && fill < CAPACITY_DEF)
			fill++;
		else if (c == CMD_DEL && p >= 1 && p <= fill)
			fill--;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	task automatic random_cmd(int k);
		int   r;
		int   mode;
		int   p;
		cmd_t c;
		mode = (k < 45) ? 0 : (k < 75) ? 1 : (k < 100) ? 2 : 1;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			c = cmd_t'($urandom_range(0, 3));
			p = $urandom_range(0, 255);
		end else begin
			case (mode)
				0: c = (r < 90) ? CMD_ADD : (r < 95) ? CMD_GET : CMD_PRINT;
				2: c = (r < 75) ? CMD_DEL : (r < 88) ? CMD_GET : CMD_PRINT;
				default: c = (r < 40) ? CMD_ADD : (r < 62) ? CMD_DEL
					: (r < 85) ? CMD_GET : CMD_PRINT;
			endcase
			if (c == CMD_ADD)
				p = $urandom_range(1, fill + 1);
			else
				p = (fill == 0) ? 1 : $urandom_range(1, fill);
			// position past the end on a full list must flag invalid, not full
			if (c == CMD_ADD && fill == CAPACITY_DEF && r % 4 == 0)
				p = fill + 2;
		end
		send_cmd(c, 8'(p), 8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_ADD;
		position = 8'h00;
		item = 8'h00;
		fill = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_cmd(CMD_PRINT, 8'd0, 8'h00);
		send_cmd(CMD_GET, 8'd1, 8'h00);
		send_cmd(CMD_DEL, 8'd1, 8'h00);
		send_cmd(CMD_ADD, 8'd0, 8'h11);
		send_cmd(CMD_ADD, 8'd2, 8'h22);
		send_cmd(CMD_ADD, 8'd1, 8'h00);
		send_cmd(CMD_ADD, 8'd2, 8'hff);
		send_cmd(CMD_ADD, 8'd1, 8'ha5);
		send_cmd(CMD_ADD, 8'd2, 8'h5a);
		send_cmd(CMD_ADD, 8'd255, 8'h01);
		send_cmd(CMD_GET, 8'd1, 8'hff);
		send_cmd(CMD_GET, 8'd4, 8'h00);
		send_cmd(CMD_GET, 8'd5, 8'h00);
		send_cmd(CMD_GET, 8'd0, 8'h00);
		send_cmd(CMD_DEL, 8'd2, 8'h00);
		send_cmd(CMD_DEL, 8'd255, 8'h00);
		send_cmd(CMD_DEL, 8'd0, 8'h00);
		send_cmd(CMD_GET, 8'd2, 8'h00);
		send_cmd(CMD_PRINT, 8'd255, 8'hff);

		for (int k = 0; k < N_RANDOM; k++)
			random_cmd(k);

		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
